[src/udas_pkg.sv]
// Shared types, constants and the cell score function of the diagonal alignment scorer.
package udas_pkg;

    localparam int MAX_QUERY = 1024;
    localparam int ALPHABET  = 32;

    localparam int QPOS_W  = $clog2(MAX_QUERY);
    localparam int RES_W   = 5;
    localparam int SCORE_W = 8;
    localparam int QLEN_W  = 11;
    localparam int CNT_W   = $clog2(MAX_QUERY + 1);
    localparam int IN_W    = QPOS_W + RES_W + SCORE_W;
    localparam int TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int CFG_W   = QLEN_W;

    localparam logic [0:0] FUNC_LOAD  = 1'b0;
    localparam logic [0:0] FUNC_SCORE = 1'b1;

    localparam logic [0:0] CFG_QLEN   = 1'b0;
    localparam logic [0:0] CFG_OFFSET = 1'b1;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic               wr_en;
        logic [QPOS_W-1:0]  wr_pos;
        logic [RES_W-1:0]   wr_res;
        logic [SCORE_W-1:0] wr_val;
        logic               rd_en;
        logic [RES_W-1:0]   rd_res;
        logic               upd;
        logic               clr;
        logic [SCORE_W-1:0] offset;
        logic [QLEN_W-1:0]  qlen;
    } t_cell_ctrl;

    // Saturating add of the previous diagonal and the profile byte, minus the offset.
    function automatic logic [SCORE_W-1:0] cell_score(
        input logic [SCORE_W-1:0] prev,
        input logic [SCORE_W-1:0] prof,
        input logic [SCORE_W-1:0] offset
    );
        logic [SCORE_W:0]   sum;
        logic [SCORE_W-1:0] sat;
        sum = {1'b0, prev} + {1'b0, prof};
        sat = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
        return (sat > offset) ? (sat - offset) : '0;
    endfunction

endpackage

[src/udas_cell.sv]
// One query position: profile column memory, diagonal score and running maximum.
module udas_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  udas_pkg::t_cell_ctrl           i_ctrl,
    input  logic [udas_pkg::QPOS_W-1:0]    i_cell_idx,
    input  logic [udas_pkg::SCORE_W-1:0]   i_s_prev,
    input  logic [udas_pkg::SCORE_W-1:0]   i_m_prev,
    output logic [udas_pkg::SCORE_W-1:0]   o_s,
    output logic [udas_pkg::SCORE_W-1:0]   o_m
);

    logic [udas_pkg::SCORE_W-1:0] r_prof_mem [udas_pkg::ALPHABET];
    logic [udas_pkg::SCORE_W-1:0] r_prof;
    logic [udas_pkg::SCORE_W-1:0] r_s;
    logic [udas_pkg::SCORE_W-1:0] r_m;
    logic [udas_pkg::SCORE_W-1:0] s_new;
    logic [udas_pkg::SCORE_W-1:0] s_cand;
    logic [udas_pkg::SCORE_W-1:0] n_m;
    logic                         active;
    logic                         upd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && (i_ctrl.wr_pos == i_cell_idx)) begin
            r_prof_mem[i_ctrl.wr_res] <= i_ctrl.wr_val;
        end
        if (i_ctrl.rd_en) begin
            r_prof <= r_prof_mem[i_ctrl.rd_res];
        end
    end

    assign active = ({1'b0, i_cell_idx} < i_ctrl.qlen);
    assign upd    = i_ctrl.upd && active;
    assign s_new  = udas_pkg::cell_score(i_s_prev, r_prof, i_ctrl.offset);
    assign s_cand = upd ? s_new : '0;

    always_comb begin
        n_m = r_m;
        if (i_m_prev > n_m) begin
            n_m = i_m_prev;
        end
        if (s_cand > n_m) begin
            n_m = s_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_m <= '0;
        end else if (i_ctrl.clr) begin
            r_s <= '0;
            r_m <= '0;
        end else begin
            if (upd) begin
                r_s <= s_new;
            end
            r_m <= n_m;
        end
    end

    assign o_s = r_s;
    assign o_m = r_m;

endmodule

[src/ungapped_diagonal_alignment_score.sv]
// Top level: controller, output register and the row of query cells.
//
// Usage:
//  - Configure query_length (index 0) and score_offset (index 1) on the write
//    port while the block is idle.
//  - Slave stream: tuser selects the item kind (0 = profile byte load,
//    1 = database residue), tlast marks the last residue of a sequence.
//  - A load writes the profile memory of one cell.
//  - Residues are taken one per cycle outside the drain; every cell below
//    query_length latches its profile byte, then its diagonal score, in parallel.
//  - After the last residue the running maximum drains down the row of
//    MAX_QUERY cells; the slave side is held off until the maximum is loaded
//    into the output register, from which best_score appears on the master side.
//  - The result sits in an output register; a stalled receiver does not hold
//    off new items, except that the next sequence's result waits for it.
//  - Reset clears all diagonal scores and the maximum; the profile memory is
//    undefined until loaded.
module ungapped_diagonal_alignment_score (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [0:0]                      i_cfg_index,
    input  logic [udas_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // query_pos [9:0], residue [14:10], profile_value [22:15], zero [23]
    input  logic [udas_pkg::TDATA_W-1:0]    s_axis_tdata,
    // func [0]
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // best_score [7:0]
    output logic [udas_pkg::SCORE_W-1:0]    m_axis_tdata
);

    localparam int RES_LO = udas_pkg::QPOS_W;
    localparam int VAL_LO = udas_pkg::QPOS_W + udas_pkg::RES_W;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state                          r_state;
    logic [udas_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_upd;
    logic [udas_pkg::QLEN_W-1:0]     r_qlen;
    logic [udas_pkg::SCORE_W-1:0]    r_offset;
    logic                            r_out_valid;
    logic [udas_pkg::SCORE_W-1:0]    r_out_data;

    logic                            in_acc;
    logic                            is_score;
    logic                            capture;
    udas_pkg::t_cell_ctrl            ctrl;

    logic [udas_pkg::SCORE_W-1:0]    s_chain [udas_pkg::MAX_QUERY];
    logic [udas_pkg::SCORE_W-1:0]    m_chain [udas_pkg::MAX_QUERY];

    assign s_axis_tready = (r_state == ST_RUN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_score      = (s_axis_tuser == udas_pkg::FUNC_SCORE);

    // Max has reached the end of the row; release it once the output is free.
    assign capture = (r_state == ST_DRAIN)
                  && (r_cnt == udas_pkg::CNT_W'(udas_pkg::MAX_QUERY))
                  && (!r_out_valid || m_axis_tready);

    always_comb begin
        ctrl.wr_en  = in_acc && !is_score;
        ctrl.wr_pos = s_axis_tdata[udas_pkg::QPOS_W-1:0];
        ctrl.wr_res = s_axis_tdata[RES_LO +: udas_pkg::RES_W];
        ctrl.wr_val = s_axis_tdata[VAL_LO +: udas_pkg::SCORE_W];
        ctrl.rd_en  = in_acc && is_score;
        ctrl.rd_res = s_axis_tdata[RES_LO +: udas_pkg::RES_W];
        ctrl.upd    = r_upd;
        ctrl.clr    = capture;
        ctrl.offset = r_offset;
        ctrl.qlen   = r_qlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen   <= udas_pkg::QLEN_W'(1);
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                udas_pkg::CFG_QLEN:   r_qlen   <= i_cfg_wdata[udas_pkg::QLEN_W-1:0];
                udas_pkg::CFG_OFFSET: r_offset <= i_cfg_wdata[udas_pkg::SCORE_W-1:0];
                default:              r_qlen   <= r_qlen;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upd <= in_acc && is_score;
            unique case (r_state)
                ST_RUN: begin
                    if (in_acc && is_score && s_axis_tlast) begin
                        r_state <= ST_DRAIN;
                        r_cnt   <= '0;
                    end
                end
                ST_DRAIN: begin
                    if (capture) begin
                        r_state <= ST_RUN;
                    end else if (r_cnt != udas_pkg::CNT_W'(udas_pkg::MAX_QUERY)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
            if (capture) begin
                r_out_valid <= 1'b1;
                r_out_data  <= m_chain[udas_pkg::MAX_QUERY-1];
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    for (genvar gi = 0; gi < udas_pkg::MAX_QUERY; gi++) begin : g_cell
        logic [udas_pkg::SCORE_W-1:0] s_in;
        logic [udas_pkg::SCORE_W-1:0] m_in;
        if (gi == 0) begin : g_head
            assign s_in = '0;
            assign m_in = '0;
        end else begin : g_body
            assign s_in = s_chain[gi-1];
            assign m_in = m_chain[gi-1];
        end
        udas_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_cell_idx (udas_pkg::QPOS_W'(gi)),
            .i_s_prev   (s_in),
            .i_m_prev   (m_in),
            .o_s        (s_chain[gi]),
            .o_m        (m_chain[gi])
        );
    end

endmodule

[src/udas_checker.sv]
// Port-level checks of the diagonal alignment scorer, bound to the top level.
module udas_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [0:0]                      s_axis_tuser,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [udas_pkg::SCORE_W-1:0]    m_axis_tdata
);

    // Hold the result while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A last residue starts the drain, so no item is taken in the next cycle.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == udas_pkg::FUNC_SCORE)
        && s_axis_tlast |=> !s_axis_tready)
        else $error("item taken during drain");

    // A new result only follows a drain, during which input was held off.
    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a drain");

endmodule

bind ungapped_diagonal_alignment_score udas_checker u_udas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
